@@ design/bfbp_pkg.sv @@
// Shared types and constants for the best-fit bin placer.
// Used by bfbp_ctrl, bfbp_dp and best_fit_bin_placer_top; no dependencies.
package bfbp_pkg;

    localparam int MAX_BINS  = 16;
    localparam int BIN_IDX_W = $clog2(MAX_BINS);
    localparam int BIN_CNT_W = 5;
    localparam int CAP_W     = 47;
    localparam int REM_W     = 48;
    localparam int LEN_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = CAP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLACK_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BEST  = 2'd1,
        OP_FIRST = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_FIT       = 3'd1,
        ST_FALLBACK  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_NO_FIT    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        EMIT_START,
        EMIT_TOO_LARGE,
        EMIT_NO_FIT
    } emit_kind_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [LEN_W-1:0]  item_length;
    } in_word_t;

    typedef struct packed {
        logic [BIN_IDX_W-1:0]     bin_index;
        status_t                  status;
        logic signed [REM_W-1:0]  remaining_after;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic        capture;
        logic        step;
        logic        commit;
        logic        emit;
        emit_kind_t  emit_kind;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t  op;
        logic     too_large;
        logic     last_bin;
        logic     ff_hit;
        logic     out_free;
    } dp_stat_t;

endpackage

@@ design/bfbp_ctrl.sv @@
// Sequencer for the best-fit bin placer: accepts words and steps the scan.
// Depends on bfbp_pkg.
module bfbp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfbp_pkg::dp_stat_t stat,
    output bfbp_pkg::dp_cmd_t  cmd
);
    import bfbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = EMIT_NO_FIT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_START:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_START;
                            state_next    = S_IDLE;
                        end
                    end
                    OP_BEST:
                    begin
                        if (!stat.too_large)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_TOO_LARGE;
                            state_next    = S_IDLE;
                        end
                    end
                    OP_FIRST:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.op == OP_FIRST)
                begin
                    if (stat.ff_hit)
                    begin
                        state_next = S_COMMIT;
                    end
                    else if (!stat.last_bin)
                    begin
                        cmd.step = 1'b1;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.last_bin)
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/bfbp_dp.sv @@
// Datapath of the best-fit bin placer: config registers, bin store,
// scan trackers and output word register. Depends on bfbp_pkg.
module bfbp_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bfbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfbp_pkg::CFG_W-1:0]         cfg_data,
    input  bfbp_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bfbp_pkg::out_word_t                out_data,
    input  bfbp_pkg::dp_cmd_t                  cmd,
    output bfbp_pkg::dp_stat_t                 stat
);
    import bfbp_pkg::*;

    localparam int SL_W = REM_W + 1;
    localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

    logic [BIN_CNT_W-1:0]      bin_count_reg;
    logic [CAP_W-1:0]          bin_capacity_reg;
    logic [CAP_W-1:0]          slack_limit_reg;

    logic signed [REM_W-1:0]   bins_reg [MAX_BINS];

    opcode_t                   op_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [BIN_IDX_W-1:0]      idx_reg;
    logic signed [SL_W-1:0]    best_slack_reg;
    logic [BIN_IDX_W-1:0]      best_idx_reg;
    logic                      found_reg;
    logic signed [REM_W-1:0]   most_reg;
    logic [BIN_IDX_W-1:0]      most_idx_reg;

    logic                      out_valid_reg;
    out_word_t                 out_reg;
    out_word_t                 out_next;

    logic [BIN_IDX_W-1:0]      last_idx;
    logic signed [REM_W-1:0]   cur_rem;
    logic signed [SL_W-1:0]    slack;
    logic                      slack_pos;
    logic                      better_fit;
    logic                      more_room;
    logic [BIN_IDX_W-1:0]      sel_idx;
    logic signed [SL_W-1:0]    diff;
    logic signed [REM_W-1:0]   rem_after;
    logic                      out_free;

    // bins in use: zero counts as one, above MAX_BINS as MAX_BINS
    always_comb
    begin
        if (bin_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (bin_count_reg > BIN_CNT_W'(MAX_BINS))
        begin
            last_idx = BIN_IDX_W'(MAX_BINS - 1);
        end
        else
        begin
            last_idx = BIN_IDX_W'(bin_count_reg - 1'b1);
        end
    end

    assign cur_rem    = bins_reg[idx_reg];
    assign slack      = {cur_rem[REM_W-1], cur_rem} - $signed({{(SL_W-LEN_W){1'b0}}, len_reg});
    assign slack_pos  = !slack[SL_W-1] && (slack != '0);
    assign better_fit = slack_pos && (slack < best_slack_reg);
    assign more_room  = (idx_reg == '0) || (cur_rem > most_reg);

    assign sel_idx = (op_reg == OP_FIRST) ? idx_reg :
                     (found_reg ? best_idx_reg : most_idx_reg);

    always_comb
    begin
        diff = {bins_reg[sel_idx][REM_W-1], bins_reg[sel_idx]}
             - $signed({{(SL_W-LEN_W){1'b0}}, len_reg});
        if (diff[SL_W-1] && !diff[REM_W-1])
        begin
            rem_after = REM_MIN;
        end
        else
        begin
            rem_after = diff[REM_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.op        = op_reg;
        stat.too_large = ({{(CAP_W-LEN_W){1'b0}}, len_reg} > bin_capacity_reg);
        stat.last_bin  = (idx_reg == last_idx);
        stat.ff_hit    = !slack[SL_W-1];
        stat.out_free  = out_free;
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.commit)
        begin
            out_next.bin_index       = sel_idx;
            out_next.status          = (op_reg == OP_FIRST || found_reg) ? ST_FIT
                                                                          : ST_FALLBACK;
            out_next.remaining_after = rem_after;
        end
        else if (cmd.emit)
        begin
            out_next.bin_index       = '0;
            out_next.remaining_after = '0;
            case (cmd.emit_kind)
                EMIT_START:
                begin
                    out_next.status          = ST_STARTED;
                    out_next.remaining_after = {1'b0, bin_capacity_reg};
                end
                EMIT_TOO_LARGE:
                begin
                    out_next.status = ST_TOO_LARGE;
                end
                default:
                begin
                    out_next.status = ST_NO_FIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg    <= BIN_CNT_W'(1);
            bin_capacity_reg <= '0;
            slack_limit_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BIN_COUNT:    bin_count_reg    <= cfg_data[BIN_CNT_W-1:0];
                    CFG_BIN_CAPACITY: bin_capacity_reg <= cfg_data[CAP_W-1:0];
                    CFG_SLACK_LIMIT:  slack_limit_reg  <= cfg_data[CAP_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.commit || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // bin store and scan state: payload, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.capture)
        begin
            op_reg         <= in_data.opcode;
            len_reg        <= in_data.item_length;
            idx_reg        <= '0;
            best_slack_reg <= $signed({{(SL_W-CAP_W){1'b0}}, slack_limit_reg});
            best_idx_reg   <= '0;
            found_reg      <= 1'b0;
            most_idx_reg   <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (better_fit)
            begin
                best_slack_reg <= slack;
                best_idx_reg   <= idx_reg;
                found_reg      <= 1'b1;
            end
            if (more_room)
            begin
                most_reg     <= cur_rem;
                most_idx_reg <= idx_reg;
            end
        end
        if (cmd.emit && cmd.emit_kind == EMIT_START)
        begin
            for (int i = 0; i < MAX_BINS; i++)
            begin
                bins_reg[i] <= {1'b0, bin_capacity_reg};
            end
        end
        else if (cmd.commit)
        begin
            bins_reg[sel_idx] <= rem_after;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ design/best_fit_bin_placer_top.sv @@
// Best-fit bin placer: usage.
// Input channel in_valid/in_ready carries one word {opcode, item_length}.
// Output channel out_valid/out_ready carries one word per input word:
// {bin_index, status, remaining_after}.
// Opcode 0 starts a job (every bin set to bin_capacity), 1 places by best
// fit with largest-bin fallback, 2 places by first fit, 3 answers no fit.
// Config: cfg_we/cfg_index/cfg_data writes bin_count (0), bin_capacity (1)
// and slack_limit (2); write only while the block is idle.
// One word at a time. Start, refusal and unused opcode are answered from
// the decode step. A placement walks the bins at one bin per cycle (bins
// in use for best fit, up to and including the hit for first fit), then
// writes its result in a commit step; first fit with no hit answers from
// the scan step at the last bin in use.
// The next word is taken as soon as the result sits in the output
// register; if the receiver stalls, the next result waits in its final
// step until the output register frees.
// Reset clears control and config (bin_count 1, others 0); bin contents
// are undefined until the first job start.
module best_fit_bin_placer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bfbp_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bfbp_pkg::out_word_t                out_data,
    input  logic                               cfg_we,
    input  logic [bfbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfbp_pkg::CFG_W-1:0]         cfg_data
);
    import bfbp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bfbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfbp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
